/* rtl/adam_pkg.sv */
// adam_pkg: shared types, widths, constants and state codes of the adam update block
// no dependencies; used by every module of the block but adam_ram by scoped names
package adam_pkg;

  localparam int FRAC_BITS       = 24;
  localparam int PARAM_COUNT_DEF = 1024;
  localparam int IDX_W           = 10;
  localparam int DATA_W          = 32;
  localparam int FX_W            = 25;
  localparam int BETA_W          = 24;
  localparam int PADDR_W         = 4;

  localparam logic [FX_W-1:0] FX_ONE = FX_W'(1) << FRAC_BITS;

  // shared multiplier
  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam logic signed [PROD_W-1:0] ACC_MAX = PROD_W'(64'h7fff_ffff);
  localparam logic signed [PROD_W-1:0] ACC_MIN = -(PROD_W'(64'h8000_0000));

  // square root unit: two radicand bits per cycle
  localparam int SQ_IN_W  = 56;
  localparam int SQ_OUT_W = SQ_IN_W / 2;
  localparam int SQ_REM_W = SQ_OUT_W + 1;

  // divider unit: one quotient bit per cycle plus an overflow check
  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 29;
  localparam int DIV_Q_W   = 33;

  // register reset values
  localparam logic [FX_W-1:0]   LEARN_RATE_RST  = FX_W'(16777);
  localparam logic [BETA_W-1:0] BETA_FIRST_RST  = BETA_W'(16609444);
  localparam logic [BETA_W-1:0] BETA_SECOND_RST = BETA_W'(16760439);
  localparam logic [FX_W-1:0]   EPSILON_RST     = FX_W'(1);

  typedef enum logic [1:0] {
    REG_LEARN_RATE,
    REG_BETA_FIRST,
    REG_BETA_SECOND,
    REG_EPSILON
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_S_SQW,
    ST_S_MUL,
    ST_S_DIV,
    ST_S_DIVW,
    ST_M_B1,
    ST_M_G1,
    ST_M_GG,
    ST_M_B2,
    ST_M_V1,
    ST_M_V2,
    ST_M_V3,
    ST_V_SAT,
    ST_A_SQW,
    ST_A_DIV,
    ST_A_DIVW,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]         param_index;
    logic signed [DATA_W-1:0] gradient;
    logic                     last_of_step;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] ascent;
    logic [DATA_W-1:0]        step_size;
    logic [IDX_W-1:0]         out_index;
    logic                     out_last;
  } out_item_t;

endpackage

/* rtl/adam_optimizer_update_top.sv */
// adam_optimizer_update_top: adam moment update with ascent and bias-corrected step size
// depends on adam_pkg, adam_ram, adam_mul, adam_sqrt, adam_div
//
//   channel   direction  handshake             payload
//   in        in         in_valid / in_ready   in_data  (adam_pkg::in_item_t)
//   out       out        out_valid / out_ready out_data (adam_pkg::out_item_t)
//   apb       in/out     psel penable pready   paddr pwrite pwdata prdata
//
// an item with a current step size waits on the 28-step square root and the 33-step divider
// besides its moment multiplies and handoffs; a last_of_step item adds the beta power updates;
// once the step count is nonzero and the first beta power is below one, the item after a
// last_of_step item or a register write rebuilds the step size (one more root, one multiply,
// one divide)
// after reset a clearing pass writes zero to all DEPTH moment entries, one per cycle;
// no item is taken meanwhile, register writes are accepted
// a finished item waits in the output register; the next item may be taken while it waits,
// and it holds in its done state until the output register is free
module adam_optimizer_update_top #(
  parameter int PARAM_COUNT = adam_pkg::PARAM_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  adam_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output adam_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adam_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // only the first 2^IDX_W entries can ever be addressed
  localparam int DEPTH = (PARAM_COUNT < (1 << adam_pkg::IDX_W)) ? PARAM_COUNT
                                                                 : (1 << adam_pkg::IDX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = 18;
  localparam int F     = adam_pkg::FRAC_BITS;
  localparam int FW    = adam_pkg::FX_W;
  localparam int MW    = adam_pkg::MUL_W;

  // configuration registers
  logic [FW-1:0]                learn_rate;
  logic [adam_pkg::BETA_W-1:0]  beta_first;
  logic [adam_pkg::BETA_W-1:0]  beta_second;
  logic [FW-1:0]                epsilon;
  logic                         cfg_wr;

  // control and item state
  adam_pkg::ctrl_state_t state, state_next;
  logic [AW-1:0]                clr_cnt;
  logic [adam_pkg::IDX_W-1:0]   idx_reg;
  logic signed [31:0]           grad_reg;
  logic                         last_reg;
  logic                         step_ok, step_ok_next;
  logic [31:0]                  step_reg, step_reg_next;
  logic [31:0]                  step_count;
  logic [FW-1:0]                pow1, pow1_next;
  logic [FW-1:0]                pow2, pow2_next;
  logic signed [31:0]           m_new, m_new_next;
  logic [38:0]                  g2_reg, g2_reg_next;
  logic signed [adam_pkg::PROD_W-1:0] acc, acc_next;
  logic signed [31:0]           asc_reg, asc_reg_next;
  logic                         count_adv;

  // shared units
  logic signed [MW-1:0]               mul_a, mul_b;
  logic signed [adam_pkg::PROD_W-1:0] prod;
  logic                               sq_start, sq_done;
  logic [adam_pkg::SQ_IN_W-1:0]       sq_in;
  logic [adam_pkg::SQ_OUT_W-1:0]      sq_root;
  logic                               dv_start, dv_done, dv_ovf;
  logic [adam_pkg::DIV_NUM_W-1:0]     dv_num;
  logic [adam_pkg::DIV_DEN_W-1:0]     dv_den;
  logic [adam_pkg::DIV_Q_W-1:0]       dv_q;

  // moment memory: first moment in the upper half, second in the lower
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [63:0]         ram_wdata;
  logic [63:0]         ram_rdata;

  // datapath helpers
  logic [FW-1:0]                b1, b2, om1, om2, p1c, p2c, d1, d2;
  logic signed [31:0]           m_old;
  logic [31:0]                  v_old, g_mag, m_mag, v_sat;
  logic signed [adam_pkg::PROD_W-1:0] acc_sh;
  logic signed [31:0]           m_sat;
  logic [adam_pkg::DIV_DEN_W-1:0] den_sum, asc_den;
  logic                         in_range;
  logic signed [31:0]           asc_val;
  logic [31:0]                  step_div;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate  <= adam_pkg::LEARN_RATE_RST;
      beta_first  <= adam_pkg::BETA_FIRST_RST;
      beta_second <= adam_pkg::BETA_SECOND_RST;
      epsilon     <= adam_pkg::EPSILON_RST;
    end else if (cfg_wr) begin
      case (adam_pkg::cfg_reg_t'(paddr[3:2]))
        adam_pkg::REG_LEARN_RATE:  learn_rate  <= pwdata[FW-1:0];
        adam_pkg::REG_BETA_FIRST:  beta_first  <= pwdata[adam_pkg::BETA_W-1:0];
        adam_pkg::REG_BETA_SECOND: beta_second <= pwdata[adam_pkg::BETA_W-1:0];
        adam_pkg::REG_EPSILON:     epsilon     <= pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (adam_pkg::cfg_reg_t'(paddr[3:2]))
      adam_pkg::REG_LEARN_RATE:  prdata = 32'(learn_rate);
      adam_pkg::REG_BETA_FIRST:  prdata = 32'(beta_first);
      adam_pkg::REG_BETA_SECOND: prdata = 32'(beta_second);
      adam_pkg::REG_EPSILON:     prdata = 32'(epsilon);
      default:                   prdata = '0;
    endcase
  end

  // units
  adam_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_moments (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_reg[AW-1:0]),
    .rdata (ram_rdata)
  );

  adam_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  adam_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_in), .done(sq_done), .root(sq_root)
  );

  adam_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .ovf(dv_ovf), .quot(dv_q)
  );

  // datapath values
  always_comb begin
    b1  = (FW'(beta_first) > adam_pkg::FX_ONE) ? adam_pkg::FX_ONE : FW'(beta_first);
    b2  = (FW'(beta_second) > adam_pkg::FX_ONE) ? adam_pkg::FX_ONE : FW'(beta_second);
    om1 = adam_pkg::FX_ONE - b1;
    om2 = adam_pkg::FX_ONE - b2;
    p1c = (pow1 > adam_pkg::FX_ONE) ? adam_pkg::FX_ONE : pow1;
    p2c = (pow2 > adam_pkg::FX_ONE) ? adam_pkg::FX_ONE : pow2;
    d1  = adam_pkg::FX_ONE - p1c;
    d2  = adam_pkg::FX_ONE - p2c;

    m_old = $signed(ram_rdata[63:32]);
    v_old = ram_rdata[31:0];
    // magnitude of the most negative value still fits as unsigned
    g_mag = grad_reg[31] ? 32'(-grad_reg) : 32'(grad_reg);
    m_mag = m_new[31] ? 32'(-m_new) : 32'(m_new);

    in_range = CMP_W'(idx_reg) < CMP_W'(PARAM_COUNT);

    // floor division by one is an arithmetic shift
    acc_sh = acc >>> F;
    if (acc_sh > adam_pkg::ACC_MAX) begin
      m_sat = 32'sh7fff_ffff;
    end else if (acc_sh < adam_pkg::ACC_MIN) begin
      m_sat = -32'sh7fff_ffff - 32'sd1;
    end else begin
      m_sat = acc_sh[31:0];
    end
    v_sat = (acc_sh > adam_pkg::ACC_MAX) ? 32'h7fff_ffff : acc_sh[31:0];

    // denominator guard: a zero sum counts as one lsb
    den_sum = adam_pkg::DIV_DEN_W'(sq_root) + adam_pkg::DIV_DEN_W'(epsilon);
    asc_den = (den_sum == '0) ? adam_pkg::DIV_DEN_W'(1) : den_sum;

    // signed saturation of the ascent quotient
    if (!m_new[31]) begin
      asc_val = (dv_ovf || dv_q[32] || dv_q[31]) ? 32'sh7fff_ffff : $signed(dv_q[31:0]);
    end else begin
      asc_val = (dv_ovf || dv_q[32] || (dv_q[31] && (dv_q[30:0] != '0)))
                ? (-32'sh7fff_ffff - 32'sd1) : $signed(32'(-dv_q[31:0]));
    end
    step_div = (dv_ovf || dv_q[32]) ? 32'hffff_ffff : dv_q[31:0];
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= adam_pkg::ST_CLEAR;
      clr_cnt    <= '0;
      step_ok    <= 1'b0;
      step_count <= '0;
      pow1       <= adam_pkg::FX_ONE;
      pow2       <= adam_pkg::FX_ONE;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      pow1    <= pow1_next;
      pow2    <= pow2_next;
      // any register write forces a fresh step size
      step_ok <= step_ok_next && !cfg_wr;
      if (state == adam_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (count_adv && (step_count != 32'hffff_ffff)) begin
        step_count <= step_count + 32'd1;
      end
      if ((state == adam_pkg::ST_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      idx_reg  <= in_data.param_index;
      grad_reg <= in_data.gradient;
      last_reg <= in_data.last_of_step;
    end
    step_reg <= step_reg_next;
    m_new    <= m_new_next;
    g2_reg   <= g2_reg_next;
    acc      <= acc_next;
    asc_reg  <= asc_reg_next;
    if ((state == adam_pkg::ST_DONE) && (!out_valid || out_ready)) begin
      // out-of-range items carry a zero ascent
      out_data.ascent    <= in_range ? asc_reg : '0;
      out_data.step_size <= step_reg;
      out_data.out_index <= idx_reg;
      out_data.out_last  <= last_reg;
    end
  end

  // next state, unit operands and register updates
  always_comb begin
    state_next    = state;
    step_ok_next  = step_ok;
    step_reg_next = step_reg;
    pow1_next     = pow1;
    pow2_next     = pow2;
    m_new_next    = m_new;
    g2_reg_next   = g2_reg;
    acc_next      = acc;
    asc_reg_next  = asc_reg;
    count_adv     = 1'b0;
    in_ready      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    sq_start      = 1'b0;
    sq_in         = '0;
    dv_start      = 1'b0;
    dv_num        = '0;
    dv_den        = asc_den;
    ram_we        = 1'b0;
    ram_waddr     = idx_reg[AW-1:0];
    ram_wdata     = {m_new, v_sat};

    case (state)
      adam_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = adam_pkg::ST_IDLE;
        end
      end
      adam_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = adam_pkg::ST_RD;
        end
      end
      adam_pkg::ST_RD: begin
        // moment read completes this cycle; step size rebuilt if stale
        if (step_ok) begin
          state_next = in_range ? adam_pkg::ST_M_B1
                     : (last_reg ? adam_pkg::ST_P1 : adam_pkg::ST_DONE);
        end else if (step_count == '0) begin
          step_reg_next = 32'(learn_rate);
          step_ok_next  = 1'b1;
          state_next    = in_range ? adam_pkg::ST_M_B1
                        : (last_reg ? adam_pkg::ST_P1 : adam_pkg::ST_DONE);
        end else if (d1 == '0) begin
          step_reg_next = 32'hffff_ffff;
          step_ok_next  = 1'b1;
          state_next    = in_range ? adam_pkg::ST_M_B1
                        : (last_reg ? adam_pkg::ST_P1 : adam_pkg::ST_DONE);
        end else begin
          sq_start   = 1'b1;
          sq_in      = adam_pkg::SQ_IN_W'({d2, {F{1'b0}}});
          state_next = adam_pkg::ST_S_SQW;
        end
      end
      adam_pkg::ST_S_SQW: begin
        if (sq_done) begin
          state_next = adam_pkg::ST_S_MUL;
        end
      end
      adam_pkg::ST_S_MUL: begin
        mul_a      = MW'(learn_rate);
        mul_b      = MW'(sq_root);
        state_next = adam_pkg::ST_S_DIV;
      end
      adam_pkg::ST_S_DIV: begin
        dv_start   = 1'b1;
        dv_num     = prod[adam_pkg::DIV_NUM_W-1:0];
        dv_den     = adam_pkg::DIV_DEN_W'(d1);
        state_next = adam_pkg::ST_S_DIVW;
      end
      adam_pkg::ST_S_DIVW: begin
        if (dv_done) begin
          step_reg_next = step_div;
          step_ok_next  = 1'b1;
          state_next    = in_range ? adam_pkg::ST_M_B1
                        : (last_reg ? adam_pkg::ST_P1 : adam_pkg::ST_DONE);
        end
      end
      adam_pkg::ST_M_B1: begin
        mul_a      = MW'(b1);
        mul_b      = MW'(m_old);
        state_next = adam_pkg::ST_M_G1;
      end
      adam_pkg::ST_M_G1: begin
        mul_a      = MW'(om1);
        mul_b      = MW'(grad_reg);
        acc_next   = prod;
        state_next = adam_pkg::ST_M_GG;
      end
      adam_pkg::ST_M_GG: begin
        mul_a      = MW'(g_mag);
        mul_b      = MW'(g_mag);
        acc_next   = acc + prod;
        state_next = adam_pkg::ST_M_B2;
      end
      adam_pkg::ST_M_B2: begin
        mul_a       = MW'(b2);
        mul_b       = MW'(v_old);
        m_new_next  = m_sat;
        g2_reg_next = prod[62:F];
        state_next  = adam_pkg::ST_M_V1;
      end
      adam_pkg::ST_M_V1: begin
        // squared gradient is wider than the multiplier: low and high parts
        mul_a      = MW'(om2);
        mul_b      = MW'(g2_reg[31:0]);
        acc_next   = prod;
        state_next = adam_pkg::ST_M_V2;
      end
      adam_pkg::ST_M_V2: begin
        mul_a      = MW'(om2);
        mul_b      = MW'(g2_reg[38:32]);
        acc_next   = acc + prod;
        state_next = adam_pkg::ST_M_V3;
      end
      adam_pkg::ST_M_V3: begin
        acc_next   = acc + (prod <<< 32);
        state_next = adam_pkg::ST_V_SAT;
      end
      adam_pkg::ST_V_SAT: begin
        ram_we     = 1'b1;
        sq_start   = 1'b1;
        sq_in      = adam_pkg::SQ_IN_W'({v_sat, {F{1'b0}}});
        state_next = adam_pkg::ST_A_SQW;
      end
      adam_pkg::ST_A_SQW: begin
        if (sq_done) begin
          state_next = adam_pkg::ST_A_DIV;
        end
      end
      adam_pkg::ST_A_DIV: begin
        dv_start   = 1'b1;
        dv_num     = adam_pkg::DIV_NUM_W'({m_mag, {F{1'b0}}});
        state_next = adam_pkg::ST_A_DIVW;
      end
      adam_pkg::ST_A_DIVW: begin
        if (dv_done) begin
          asc_reg_next = asc_val;
          state_next   = last_reg ? adam_pkg::ST_P1 : adam_pkg::ST_DONE;
        end
      end
      adam_pkg::ST_P1: begin
        mul_a      = MW'(pow1);
        mul_b      = MW'(b1);
        state_next = adam_pkg::ST_P2;
      end
      adam_pkg::ST_P2: begin
        mul_a      = MW'(pow2);
        mul_b      = MW'(b2);
        pow1_next  = prod[F+FW-1:F];
        state_next = adam_pkg::ST_P3;
      end
      adam_pkg::ST_P3: begin
        pow2_next    = prod[F+FW-1:F];
        count_adv    = 1'b1;
        step_ok_next = 1'b0;
        state_next   = adam_pkg::ST_DONE;
      end
      adam_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = adam_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = adam_pkg::ST_IDLE;
      end
    endcase
  end

  // checks
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> step_count >= $past(step_count))
    else $error("step count went backwards");

  a_ram_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == adam_pkg::ST_CLEAR) || (state == adam_pkg::ST_V_SAT))
    else $error("moment write outside clear pass or update");

  a_powers_bounded: assert property (@(posedge clk) disable iff (rst)
    (pow1 <= adam_pkg::FX_ONE) && (pow2 <= adam_pkg::FX_ONE))
    else $error("beta power above one");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == adam_pkg::ST_RD)
    else $error("accepted item did not start the moment read");

endmodule

/* rtl/adam_ram.sv */
// adam_ram: generic single-write, single-read memory with registered read data
// no dependencies
module adam_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/adam_mul.sv */
// adam_mul: shared signed multiplier with registered product
// depends on adam_pkg for operand widths
module adam_mul (
  input  logic                                 clk,
  input  logic signed [adam_pkg::MUL_W-1:0]    a,
  input  logic signed [adam_pkg::MUL_W-1:0]    b,
  output logic signed [adam_pkg::PROD_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* rtl/adam_sqrt.sv */
// adam_sqrt: iterative integer square root, two radicand bits per cycle
// depends on adam_pkg for widths
module adam_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [adam_pkg::SQ_IN_W-1:0]      radicand,
  output logic                              done,
  output logic [adam_pkg::SQ_OUT_W-1:0]     root
);

  localparam int CW = $clog2(adam_pkg::SQ_OUT_W);

  logic [adam_pkg::SQ_IN_W-1:0]  rad;
  logic [adam_pkg::SQ_REM_W-1:0] rem;
  logic [CW-1:0]                 cnt;
  logic                          busy;

  logic [adam_pkg::SQ_REM_W+1:0] rem_sh;
  logic [adam_pkg::SQ_REM_W+1:0] trial;
  logic                          ge;

  always_comb begin
    rem_sh = {rem, rad[adam_pkg::SQ_IN_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rad  <= rad << 2;
        rem  <= ge ? adam_pkg::SQ_REM_W'(rem_sh - trial) : rem_sh[adam_pkg::SQ_REM_W-1:0];
        root <= {root[adam_pkg::SQ_OUT_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(adam_pkg::SQ_OUT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/adam_div.sv */
// adam_div: iterative restoring divider, one quotient bit per cycle
// flags quotients that do not fit the quotient width; depends on adam_pkg
module adam_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [adam_pkg::DIV_NUM_W-1:0]     num,
  input  logic [adam_pkg::DIV_DEN_W-1:0]     den,
  output logic                               done,
  output logic                               ovf,
  output logic [adam_pkg::DIV_Q_W-1:0]       quot
);

  localparam int QW = adam_pkg::DIV_Q_W;
  localparam int DW = adam_pkg::DIV_DEN_W;
  localparam int HW = adam_pkg::DIV_NUM_W - QW;
  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] den_reg;
  logic [DW-1:0] rem;
  logic [QW-1:0] nlo;
  logic [CW-1:0] cnt;
  logic          busy;

  logic [DW:0]   rem_sh;
  logic          ge;

  always_comb begin
    rem_sh = {rem, nlo[QW-1]};
    ge     = (rem_sh >= {1'b0, den_reg});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ovf     <= (DW'(num[adam_pkg::DIV_NUM_W-1 -: HW]) >= den);
        rem     <= DW'(num[adam_pkg::DIV_NUM_W-1 -: HW]);
        nlo     <= num[QW-1:0];
        den_reg <= den;
        quot    <= '0;
        cnt     <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
        nlo  <= nlo << 1;
        quot <= {quot[QW-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
